// ===== hdl/assert_macros.svh =====
// assertion helper macros for the elgamal block
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in this cycle, consequent in the next one
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/eg_pkg.sv =====
// shared constants for the elgamal encrypt/decrypt block
// no dependencies
package eg_pkg;

    // opcode carried in the input tuser bit
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_PRIME     = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PUBLIC    = 2'd2;
    localparam logic [1:0] REG_PRIVATE   = 2'd3;

    // field width of the stream words
    localparam int FIELD_BITS = 32;

endpackage

// ===== hdl/elgamal_encrypt_decrypt.sv =====
// elgamal encrypt/decrypt, W = MOD_BITS; encrypt runs y^r and g^r side by side, then c2 = y^r * m;
// decrypt runs c1^d, the euclid loop for its inverse, then one multiply
// throughput: one word at a time, set by the bit-serial modular multiply-add unit
// (one multiplier bit per cycle) and the bit-serial divider in the euclid loop
// a finished result waits in the output register while the next word is accepted
// reset (i_rst_n low, synchronous) clears control and loads p=3, g=2, y=2, d=3
`include "assert_macros.svh"

module elgamal_encrypt_decrypt #(
    parameter int MOD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // message_or_c2, c1_value, ephemeral_r
    input  logic        s_axis_tuser,  // opcode
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // first_value, second_value
    output logic        m_axis_tuser   // status
);

    localparam int W  = MOD_BITS;
    localparam int CW = $clog2(W);
    localparam int FB = eg_pkg::FIELD_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_RED1, S_RED2, S_PSQ, S_PMU, S_PADV,
        S_ECHK, S_EDIV, S_EUPD, S_FIN, S_OUT
    } t_state;

    // one step of the serial modular multiplier: (2*acc + b*add) mod p, sum < 3p before reduction
    function automatic logic [W-1:0] f_mstep(input logic [W-1:0] acc,
                                             input logic [W-1:0] add,
                                             input logic         b,
                                             input logic [W-1:0] p);
        logic [W+1:0] t;
        logic [W+1:0] p1;
        logic [W+1:0] p2;
        t  = {1'b0, acc, 1'b0} + (b ? {2'b00, add} : '0);
        p1 = {2'b00, p};
        p2 = {1'b0, p, 1'b0};
        if (t >= p2) begin
            f_mstep = W'(t - p2);
        end else if (t >= p1) begin
            f_mstep = W'(t - p1);
        end else begin
            f_mstep = W'(t);
        end
    endfunction

    t_state         r_state;

    // configuration
    logic [W-1:0]   r_p, r_g, r_y, r_d;

    // captured word
    logic           r_op;
    logic [W-1:0]   r_er;

    // two multiplier lanes: accumulator, addend, multiplier bit shifter
    logic [W-1:0]   r_acc_a, r_add_a, r_bits_a;
    logic [W-1:0]   r_acc_b, r_add_b, r_bits_b;
    logic [CW-1:0]  r_cnt;

    // exponentiation state
    logic [W-1:0]   r_m, r_ba, r_bb, r_za, r_zb, r_e;
    logic [CW-1:0]  r_ecnt;

    // extended euclid state
    logic [W-1:0]   r_r1, r_r2, r_t1, r_t2, r_rem;

    // result staging and output register
    logic [W-1:0]   r_first, r_second;
    logic           r_status;
    logic           r_ovalid;
    logic [63:0]    r_odata;
    logic           r_ouser;

    // next values of the serial units
    logic [W:0]     d_num;
    logic           q_bit;
    logic [W-1:0]   n_rem;
    logic           bit_a;
    logic [W-1:0]   n_acc_a, n_acc_b;
    logic [W-1:0]   n_sub;
    logic           last_bit;

    // divider: restoring, one quotient bit per cycle, dividend bits from lane a shifter
    always_comb begin
        d_num = {r_rem, r_bits_a[W-1]};
        q_bit = (d_num >= {1'b0, r_r2});
        n_rem = q_bit ? W'(d_num - {1'b0, r_r2}) : W'(d_num);
    end

    // lane a takes quotient bits during division so q*t2 mod p builds alongside
    assign bit_a   = (r_state == S_EDIV) ? q_bit : r_bits_a[W-1];
    assign n_acc_a = f_mstep(r_acc_a, r_add_a, bit_a, r_p);
    assign n_acc_b = f_mstep(r_acc_b, r_add_b, r_bits_b[W-1], r_p);

    // t1 - q*t2 mod p
    assign n_sub = (r_t1 >= r_acc_a) ? (r_t1 - r_acc_a)
                                     : W'({1'b0, r_t1} + {1'b0, r_p} - {1'b0, r_acc_a});

    assign last_bit = (r_cnt == CW'(W - 1));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_p      <= W'(3);
            r_g      <= W'(2);
            r_y      <= W'(2);
            r_d      <= W'(3);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    eg_pkg::REG_PRIME:     r_p <= W'(i_cfg_data);
                    eg_pkg::REG_GENERATOR: r_g <= W'(i_cfg_data);
                    eg_pkg::REG_PUBLIC:    r_y <= W'(i_cfg_data);
                    eg_pkg::REG_PRIVATE:   r_d <= W'(i_cfg_data);
                    default: ;
                endcase
            end

            // the output register empties when taken, unless a new word loads it
            if (r_ovalid && m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= s_axis_tuser;
                        r_er     <= W'(s_axis_tdata[3*FB-1:2*FB]);
                        r_first  <= '0;
                        r_second <= '0;
                        if (r_p < W'(2)) begin
                            // degenerate modulus: zero values, status follows opcode
                            r_status <= s_axis_tuser;
                            r_state  <= S_OUT;
                        end else begin
                            // reduce message and base by multiplying with one
                            r_acc_a  <= '0;
                            r_add_a  <= W'(1);
                            r_bits_a <= W'(s_axis_tdata[FB-1:0]);
                            r_acc_b  <= '0;
                            r_add_b  <= W'(1);
                            r_bits_b <= (s_axis_tuser == eg_pkg::OP_DECRYPT)
                                        ? W'(s_axis_tdata[2*FB-1:FB]) : r_g;
                            r_cnt    <= '0;
                            r_status <= 1'b0;
                            r_state  <= S_RED1;
                        end
                    end
                end
                S_RED1: begin
                    if (last_bit) begin
                        r_m  <= n_acc_a;
                        r_bb <= n_acc_b;
                        r_za <= W'(1);
                        r_zb <= W'(1);
                        if (r_op == eg_pkg::OP_DECRYPT) begin
                            // start c1^d with z = 1; lane a idles on a unit base
                            r_ba     <= W'(1);
                            r_e      <= r_d;
                            r_ecnt   <= '0;
                            r_acc_a  <= '0;
                            r_add_a  <= W'(1);
                            r_bits_a <= W'(1);
                            r_acc_b  <= '0;
                            r_add_b  <= W'(1);
                            r_bits_b <= W'(1);
                            r_cnt    <= '0;
                            r_state  <= S_PSQ;
                        end else begin
                            r_acc_a  <= '0;
                            r_add_a  <= W'(1);
                            r_bits_a <= r_y;
                            r_cnt    <= '0;
                            r_state  <= S_RED2;
                        end
                    end else begin
                        r_acc_a  <= n_acc_a;
                        r_acc_b  <= n_acc_b;
                        r_bits_a <= r_bits_a << 1;
                        r_bits_b <= r_bits_b << 1;
                        r_cnt    <= r_cnt + 1'b1;
                    end
                end
                S_RED2: begin
                    if (last_bit) begin
                        // lane a runs y^r, lane b runs g^r
                        r_ba     <= n_acc_a;
                        r_e      <= r_er;
                        r_ecnt   <= '0;
                        r_acc_a  <= '0;
                        r_add_a  <= W'(1);
                        r_bits_a <= W'(1);
                        r_acc_b  <= '0;
                        r_add_b  <= W'(1);
                        r_bits_b <= W'(1);
                        r_cnt    <= '0;
                        r_state  <= S_PSQ;
                    end else begin
                        r_acc_a  <= n_acc_a;
                        r_bits_a <= r_bits_a << 1;
                        r_cnt    <= r_cnt + 1'b1;
                    end
                end
                S_PSQ: begin
                    if (last_bit) begin
                        r_za <= n_acc_a;
                        r_zb <= n_acc_b;
                        if (r_e[W-1]) begin
                            // exponent bit set: multiply by the base
                            r_acc_a  <= '0;
                            r_add_a  <= r_ba;
                            r_bits_a <= n_acc_a;
                            r_acc_b  <= '0;
                            r_add_b  <= r_bb;
                            r_bits_b <= n_acc_b;
                            r_cnt    <= '0;
                            r_state  <= S_PMU;
                        end else begin
                            r_state <= S_PADV;
                        end
                    end else begin
                        r_acc_a  <= n_acc_a;
                        r_acc_b  <= n_acc_b;
                        r_bits_a <= r_bits_a << 1;
                        r_bits_b <= r_bits_b << 1;
                        r_cnt    <= r_cnt + 1'b1;
                    end
                end
                S_PMU: begin
                    r_acc_a  <= n_acc_a;
                    r_acc_b  <= n_acc_b;
                    r_bits_a <= r_bits_a << 1;
                    r_bits_b <= r_bits_b << 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (last_bit) begin
                        r_za    <= n_acc_a;
                        r_zb    <= n_acc_b;
                        r_state <= S_PADV;
                    end
                end
                S_PADV: begin
                    r_cnt   <= '0;
                    r_acc_a <= '0;
                    r_acc_b <= '0;
                    if (r_ecnt == CW'(W - 1)) begin
                        if (r_op == eg_pkg::OP_DECRYPT) begin
                            // euclid on (p, s) with t1 = 0, t2 = 1
                            r_r1    <= r_p;
                            r_r2    <= r_zb;
                            r_t1    <= '0;
                            r_t2    <= W'(1);
                            r_state <= S_ECHK;
                        end else begin
                            // c2 = y^r * m
                            r_add_a  <= r_m;
                            r_bits_a <= r_za;
                            r_state  <= S_FIN;
                        end
                    end else begin
                        r_e      <= r_e << 1;
                        r_ecnt   <= r_ecnt + 1'b1;
                        r_add_a  <= r_za;
                        r_bits_a <= r_za;
                        r_add_b  <= r_zb;
                        r_bits_b <= r_zb;
                        r_state  <= S_PSQ;
                    end
                end
                S_ECHK: begin
                    r_cnt   <= '0;
                    r_acc_a <= '0;
                    if (r_r2 == '0) begin
                        if (r_r1 == W'(1)) begin
                            // plaintext = c2 * inverse
                            r_add_a  <= r_m;
                            r_bits_a <= r_t1;
                            r_state  <= S_FIN;
                        end else begin
                            // no inverse
                            r_status <= 1'b1;
                            r_state  <= S_OUT;
                        end
                    end else begin
                        r_bits_a <= r_r1;
                        r_add_a  <= r_t2;
                        r_rem    <= '0;
                        r_state  <= S_EDIV;
                    end
                end
                S_EDIV: begin
                    r_acc_a  <= n_acc_a;
                    r_rem    <= n_rem;
                    r_bits_a <= r_bits_a << 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (last_bit) begin
                        r_state <= S_EUPD;
                    end
                end
                S_EUPD: begin
                    r_r1    <= r_r2;
                    r_r2    <= r_rem;
                    r_t1    <= r_t2;
                    r_t2    <= n_sub;
                    r_state <= S_ECHK;
                end
                S_FIN: begin
                    r_acc_a  <= n_acc_a;
                    r_bits_a <= r_bits_a << 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (last_bit) begin
                        if (r_op == eg_pkg::OP_DECRYPT) begin
                            r_first <= n_acc_a;
                        end else begin
                            r_first  <= r_zb;
                            r_second <= n_acc_a;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait until the output register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {FB'(r_second), FB'(r_first)};
                        r_ouser  <= r_status;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted word always starts work
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state != S_IDLE, "accepted word did not start work")

    // multiplier lane stays reduced during exponentiation
    `ASSERT_SAME(a_acc_reduced, i_clk, i_rst_n, (r_state == S_PSQ) || (r_state == S_PMU), r_acc_a < r_p, "lane a accumulator not reduced")

    // a set status (no inverse, or decrypt on a degenerate modulus) carries zero values
    `ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "status set with nonzero data")

endmodule

// ===== tb/elgamal_checker.sv =====
// result checker for the elgamal encrypt/decrypt block
// depends on eg_pkg; watches config port and both stream channels
`timescale 1ns / 1ps

module elgamal_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [95:0] i_s_tdata,   // message_or_c2, c1_value, ephemeral_r
    input  logic        i_s_tuser,   // opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // first_value, second_value
    input  logic        i_m_tuser,   // status
    output int          o_pending,
    output int          o_errors
);

    typedef struct packed {
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic        status;
    } t_eg_result;

    logic [63:0] mod_p, base_g, key_y, key_d;
    t_eg_result  want_mem [0:7];     // expected words in arrival order
    logic [2:0]  wr_ptr, rd_ptr;
    int          n_pend;
    int          n_err = 0;

    assign o_pending = n_pend;
    assign o_errors  = n_err;

    function automatic logic [63:0] add_m(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [63:0] s;
        s = a + b;
        if (s < a || s >= n) s = s - n;
        return s;
    endfunction

    function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [63:0] acc;
        acc = 0;
        for (int i = 63; i >= 0; i--) begin
            acc = add_m(acc, acc, n);
            if (b[i]) acc = add_m(acc, a, n);
        end
        return acc;
    endfunction

    function automatic logic [63:0] pow_m(logic [63:0] b, logic [63:0] e, logic [63:0] n);
        logic [63:0] z;
        z = 1;
        b = b % n;
        for (int i = 63; i >= 0; i--) begin
            z = mul_m(z, z, n);
            if (e[i]) z = mul_m(z, b, n);
        end
        return z;
    endfunction

    // extended euclid, coefficients kept in [0, n); returns 0 when gcd != 1
    function automatic bit inv_m(logic [63:0] a, logic [63:0] n, output logic [63:0] inv);
        logic [63:0] r1, r2, t1, t2, q, r, t, m;
        r1 = n; r2 = a; t1 = 0; t2 = 1; inv = 0;
        while (r2 != 0) begin
            q = r1 / r2;
            r = r1 - q * r2;
            m = mul_m(q % n, t2, n);
            t = (t1 >= m) ? t1 - m : t1 + (n - m);
            r1 = r2; r2 = r; t1 = t2; t2 = t;
        end
        inv = t1;
        return (r1 == 1);
    endfunction

    function automatic t_eg_result elgamal_predict(logic op, logic [31:0] mc,
                                                   logic [31:0] c1, logic [31:0] r);
        t_eg_result  res;
        logic [63:0] s, inv;
        res = '0;
        if (mod_p < 2) begin
            res.status = op;
        end else if (op == eg_pkg::OP_ENCRYPT) begin
            res.first_value  = 32'(pow_m(base_g, 64'(r), mod_p));
            res.second_value = 32'(mul_m(pow_m(key_y, 64'(r), mod_p),
                                         64'(mc) % mod_p, mod_p));
        end else begin
            s = pow_m(64'(c1), key_d, mod_p);
            if (inv_m(s, mod_p, inv)) res.first_value = 32'(mul_m(64'(mc) % mod_p, inv, mod_p));
            else res.status = 1'b1;
        end
        return res;
    endfunction

    task automatic report_bad(string what, logic [31:0] got, logic [31:0] exp_v);
        $display("checker: %s mismatch, got %h expected %h", what, got, exp_v);
        n_err++;
    endtask

    always @(posedge i_clk) begin
        t_eg_result w;
        int         in_n;
        int         out_n;
        if (!i_rst_n) begin
            mod_p  <= 3; base_g <= 2; key_y <= 2; key_d <= 3;
            wr_ptr <= '0;
            rd_ptr <= '0;
            n_pend <= 0;
        end else begin
            in_n  = 0;
            out_n = 0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    eg_pkg::REG_PRIME:     mod_p  <= 64'(i_cfg_data);
                    eg_pkg::REG_GENERATOR: base_g <= 64'(i_cfg_data);
                    eg_pkg::REG_PUBLIC:    key_y  <= 64'(i_cfg_data);
                    eg_pkg::REG_PRIVATE:   key_d  <= 64'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                want_mem[wr_ptr] <= elgamal_predict(i_s_tuser, i_s_tdata[31:0],
                                                    i_s_tdata[63:32], i_s_tdata[95:64]);
                wr_ptr <= wr_ptr + 3'd1;
                in_n = 1;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (n_pend == 0) begin
                    report_bad("unexpected word", i_m_tdata[31:0], 32'd0);
                end else begin
                    w = want_mem[rd_ptr];
                    rd_ptr <= rd_ptr + 3'd1;
                    out_n = 1;
                    if (i_m_tdata[31:0] !== w.first_value)
                        report_bad("first_value", i_m_tdata[31:0], w.first_value);
                    if (i_m_tdata[63:32] !== w.second_value)
                        report_bad("second_value", i_m_tdata[63:32], w.second_value);
                    if (i_m_tuser !== w.status)
                        report_bad("status", 32'(i_m_tuser), 32'(w.status));
                end
            end
            n_pend <= n_pend + in_n - out_n;
        end
    end
endmodule

// ===== tb/tb.sv =====
// top of the elgamal encrypt/decrypt testbench: clock, reset, stimulus, verdict
// depends on eg_pkg, elgamal_checker and the elgamal_encrypt_decrypt block
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES = 4_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // message_or_c2, c1_value, ephemeral_r
    logic        s_axis_tuser;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // first_value, second_value
    logic        m_axis_tuser;   // status

    int          pending, errors;
    int          idle_mode;      // 0 none, 1 sender gaps, 2 receiver stalls, 3 both light
    int          cycles = 0;
    logic [31:0] cur_p;          // modulus as last written, to aim operands below it

    elgamal_encrypt_decrypt dut (.*);

    elgamal_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle guard against a hung block
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver side: stall at random according to the current idling phase
    always @(posedge i_clk) begin
        case (idle_mode)
            2:       m_axis_tready <= ($urandom_range(0, 99) >= 74);
            3:       m_axis_tready <= ($urandom_range(0, 99) >= 9);
            default: m_axis_tready <= 1'b1;
        endcase
    end

    // one register write; the caller lowers the write enable after the batch
    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        if (idx == eg_pkg::REG_PRIME) cur_p = val;
        @(posedge i_clk);
    endtask

    // drop tvalid, wait until every expected word is back, plus some margin
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic load_keys(logic [31:0] p, logic [31:0] g, logic [31:0] y, logic [31:0] d);
        drain();
        cfg_write(eg_pkg::REG_PRIME, p);
        cfg_write(eg_pkg::REG_GENERATOR, g);
        cfg_write(eg_pkg::REG_PUBLIC, y);
        cfg_write(eg_pkg::REG_PRIVATE, d);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // present one word and hold it until accepted; tvalid stays high afterwards
    task automatic send_word(logic op, logic [31:0] mc, logic [31:0] c1, logic [31:0] r);
        int gap;
        gap = 0;
        if (idle_mode == 1 && $urandom_range(0, 99) < 74) gap = $urandom_range(1, 6);
        if (idle_mode == 3 && $urandom_range(0, 99) < 9)  gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {r, c1, mc};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // operand either full range or below the modulus
    function automatic logic [31:0] pick_operand();
        if (cur_p >= 2 && $urandom_range(0, 1)) return $urandom_range(0, cur_p - 1);
        return $urandom();
    endfunction

    task automatic random_words(int count);
        logic op;
        for (int k = 0; k < count; k++) begin
            op = 1'($urandom_range(0, 1));
            if (op == eg_pkg::OP_DECRYPT && $urandom_range(0, 9) == 0)
                send_word(op, pick_operand(), 32'd0, $urandom());   // zero c1, no inverse
            else
                send_word(op, pick_operand(), pick_operand(), $urandom());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = eg_pkg::REG_PRIME;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = eg_pkg::OP_ENCRYPT;
        idle_mode     = 0;
        cur_p         = 32'd3;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words on the reset keys: zero exponent, extremes, operands above p
        send_word(eg_pkg::OP_ENCRYPT, 32'd0, 32'd0, 32'd0);
        send_word(eg_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(eg_pkg::OP_ENCRYPT, 32'd7, 32'd0, 32'd5);
        send_word(eg_pkg::OP_DECRYPT, 32'd2, 32'd0, 32'd0);              // c1 = 0, no inverse
        send_word(eg_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);  // c1 multiple of p
        send_word(eg_pkg::OP_DECRYPT, 32'd5, 32'd4, 32'hFFFF_FFFF);

        // largest 32-bit prime, extreme keys
        load_keys(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(eg_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_word(eg_pkg::OP_ENCRYPT, 32'hFFFF_FFFB, 32'd0, 32'd1);
        send_word(eg_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'd0);   // c1 == p
        send_word(eg_pkg::OP_DECRYPT, 32'hFFFF_FFFA, 32'hFFFF_FFFA, 32'd0);
        send_word(eg_pkg::OP_DECRYPT, 32'd1, 32'd1, 32'd0);
        random_words(26);

        // modulus below two: value fields all zero
        load_keys(32'd1, 32'd1, 32'd1, 32'd1);
        idle_mode = 1;
        send_word(eg_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        send_word(eg_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        random_words(6);
        load_keys(32'd0, 32'd2, 32'd2, 32'd3);
        send_word(eg_pkg::OP_ENCRYPT, 32'd9, 32'd9, 32'd9);
        send_word(eg_pkg::OP_DECRYPT, 32'd9, 32'd9, 32'd9);

        // small prime with a real key pair: g = 5, d = 6, y = 5^6 mod 23 = 8
        load_keys(32'd23, 32'd5, 32'd8, 32'd6);
        random_words(30);

        // composite modulus: gcd failures appear naturally
        load_keys(32'hFFFF_FFFF, 32'h1234_5677, 32'h0BAD_F00D, 32'd65537);
        idle_mode = 2;
        random_words(30);

        // mid-size prime, both sides lightly idle
        load_keys(32'd2_147_483_647, 32'd7, 32'hDEAD_BEEF, 32'd1);
        idle_mode = 3;
        random_words(30);
        idle_mode = 0;
        random_words(10);

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
